// ===== hw/rtl/mfl_pkg.sv =====
// mfl_pkg: shared widths, codes and constants of the message flood limiter.
// No dependencies; imported by the channel interfaces and the top level.
package mfl_pkg;

    localparam int FRAME_W   = 32;
    localparam int VERDICT_W = 2;
    localparam int WAIT_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int MAXMSG_W  = 5;
    localparam int WINF_W    = 20;   // window in frames, up to 655350
    localparam int DIFF_W    = 17;   // lock remaining, below the wait saturation point

    localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_LOCKED = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_FLOOD  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MESSAGES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_FRAMES    = 2'd2;

    localparam logic [MAXMSG_W-1:0]  RST_MAX_MESSAGES = 5'd4;
    localparam logic [WINF_W-1:0]    RST_WIN_FRAMES   = 20'd40;
    localparam logic [CFG_DAT_W-1:0] RST_LOCK_FRAMES  = 16'd100;

    localparam logic [WAIT_W-1:0]  WAIT_MAX        = 13'd8191;
    // (WAIT_MAX + 1) * 10 frames: at or above this the wait saturates
    localparam logic [FRAME_W-1:0] WAIT_SAT_FRAMES = 32'd81920;
    // x / 10 == (x * 52429) >> 19 for every x below WAIT_SAT_FRAMES
    localparam logic [15:0]        DIV10_RECIP     = 16'd52429;
    localparam int                 DIV10_SHIFT     = 19;

endpackage

// ===== hw/rtl/mfl_ifs.sv =====
// mfl_ifs: valid/ready channel interfaces for attempt and verdict beats.
// Depends on mfl_pkg for field widths.
interface mfl_in_if
    import mfl_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] frame_now;

    modport source (output valid, output frame_now, input ready);
    modport sink   (input valid, input frame_now, output ready);
endinterface

interface mfl_out_if
    import mfl_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;
    logic [WAIT_W-1:0]    wait_seconds;

    modport source (output valid, output verdict, output wait_seconds, input ready);
    modport sink   (input valid, input verdict, input wait_seconds, output ready);
endinterface

// ===== hw/rtl/message_flood_limiter.sv =====
// Steps from attempt beat to verdict beat: ring read, decide, wait scaling, each registered.
// Throughput: one attempt per cycle unless the verdict side stalls; the ring is read on
// accept and written back when the attempt decides, with a forward path between them.
// Reset (synchronous, active low) restores the registers to 4 / 4 s / 100 frames
// and clears the per-slot valid bits at once, so the ring reads empty; no clearing pass.
// Depends on mfl_pkg and mfl_ifs.
module message_flood_limiter
    import mfl_pkg::*;
#(
    parameter int RING_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    mfl_in_if.sink               i_in,
    mfl_out_if.source            o_out
);

    localparam int              AW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [AW-1:0]   LAST = AW'(RING_DEPTH - 1);

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] h);
        logic [AW-1:0] r;
        r = (h == LAST) ? '0 : h + AW'(1);
        return r;
    endfunction

    function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] h,
                                                 input logic [AW-1:0] b);
        logic [AW:0] s;
        if (h >= b) begin
            s = {1'b0, h} - {1'b0, b};
        end else begin
            s = {1'b0, h} + (AW+1)'(RING_DEPTH) - {1'b0, b};
        end
        return s[AW-1:0];
    endfunction

    // configuration
    logic [MAXMSG_W-1:0]  r_max;
    logic [WINF_W-1:0]    r_win_frames;
    logic [CFG_DAT_W-1:0] r_lock_frames;

    // ring state
    logic [FRAME_W-1:0]    r_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_valid;
    logic [AW-1:0]         r_head;
    logic [FRAME_W-1:0]    r_lock_until;

    // decide stage
    logic               r_s1_v;
    logic [FRAME_W-1:0] r_s1_frame;
    logic [FRAME_W-1:0] r_rd_a;      // slot behind head as it stood on accept
    logic [FRAME_W-1:0] r_rd_b;      // same, had the head moved one on
    logic               r_s1_adv;    // the attempt ahead stored a frame on our accept
    logic [AW-1:0]      r_fwd_addr;
    logic [FRAME_W-1:0] r_fwd_data;

    // wait scaling stage
    logic                 r_s2_v;
    logic [VERDICT_W-1:0] r_s2_verdict;
    logic                 r_s2_sat;
    logic [DIFF_W-1:0]    r_s2_diff;

    // output register
    logic                 r_out_v;
    logic [VERDICT_W-1:0] r_out_verdict;
    logic [WAIT_W-1:0]    r_out_wait;

    logic                 out_free, s2_free, s1_free, s1_move, in_acc;
    logic [AW-1:0]        back, slot, w_addr;
    logic [FRAME_W-1:0]   rd_sel, stamp, age, diff;
    logic                 locked, recent, do_write;
    logic [VERDICT_W-1:0] verdict;
    logic [FRAME_W:0]     lock_sum;
    logic [FRAME_W-1:0]   lock_end;
    logic [32:0]          prod;
    logic [WAIT_W-1:0]    wait_s2;

    assign out_free = !r_out_v || o_out.ready;
    assign s2_free  = !r_s2_v || out_free;
    assign s1_free  = !r_s1_v || s2_free;
    assign s1_move  = r_s1_v && s2_free;
    assign in_acc   = i_in.valid && i_in.ready;

    assign i_in.ready         = s1_free;
    assign o_out.valid        = r_out_v;
    assign o_out.verdict      = r_out_verdict;
    assign o_out.wait_seconds = r_out_wait;

    always_comb begin
        if (32'(r_max) >= 32'(RING_DEPTH)) begin
            back = LAST;
        end else begin
            back = AW'(r_max - MAXMSG_W'(1));
        end
    end

    // decide
    always_comb begin
        slot   = ring_back(r_head, back);
        w_addr = ring_inc(r_head);
        rd_sel = r_s1_adv ? r_rd_b : r_rd_a;
        if (r_s1_adv && (r_fwd_addr == slot)) begin
            rd_sel = r_fwd_data;
        end
        stamp  = r_valid[slot] ? rd_sel : '0;
        age    = r_s1_frame - stamp;
        recent = (stamp != '0) && (age < FRAME_W'(r_win_frames));
        locked = r_s1_frame < r_lock_until;
        diff   = r_lock_until - r_s1_frame;

        priority if (r_max == '0) begin
            verdict = VERDICT_ACCEPT;
        end else if (locked) begin
            verdict = VERDICT_LOCKED;
        end else if (recent) begin
            verdict = VERDICT_FLOOD;
        end else begin
            verdict = VERDICT_ACCEPT;
        end
        do_write = s1_move && (r_max != '0) && (verdict == VERDICT_ACCEPT);

        lock_sum = {1'b0, r_s1_frame} + (FRAME_W+1)'(r_lock_frames);
        lock_end = lock_sum[FRAME_W] ? '1 : lock_sum[FRAME_W-1:0];
    end

    // wait = diff / 10, saturated
    always_comb begin
        prod = 33'(r_s2_diff) * 33'(DIV10_RECIP);
        if (r_s2_sat) begin
            wait_s2 = WAIT_MAX;
        end else begin
            wait_s2 = prod[DIV10_SHIFT+WAIT_W-1:DIV10_SHIFT];
        end
    end

    // ring memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[w_addr] <= r_s1_frame;
        end
        if (in_acc) begin
            r_rd_a <= r_mem[ring_back(r_head, back)];
            r_rd_b <= r_mem[ring_back(ring_inc(r_head), back)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max         <= RST_MAX_MESSAGES;
            r_win_frames  <= RST_WIN_FRAMES;
            r_lock_frames <= RST_LOCK_FRAMES;
            r_valid       <= '0;
            r_head        <= '0;
            r_lock_until  <= '0;
            r_s1_v        <= 1'b0;
            r_s1_adv      <= 1'b0;
            r_s2_v        <= 1'b0;
            r_out_v       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MAX_MESSAGES:   r_max <= i_cfg_data[MAXMSG_W-1:0];
                    CFG_WINDOW_SECONDS: r_win_frames <= ({4'd0, i_cfg_data} << 3)
                                                      + ({4'd0, i_cfg_data} << 1);
                    CFG_LOCK_FRAMES:    r_lock_frames <= i_cfg_data;
                    default: ;
                endcase
            end

            if (do_write) begin
                r_head          <= w_addr;
                r_valid[w_addr] <= 1'b1;
            end
            if (s1_move && (r_max != '0) && !locked && recent) begin
                r_lock_until <= lock_end;
            end

            if (in_acc) begin
                r_s1_v   <= 1'b1;
                r_s1_adv <= do_write;
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end

            if (s1_move) begin
                r_s2_v <= 1'b1;
            end else if (s2_free) begin
                r_s2_v <= 1'b0;
            end

            if (r_s2_v && out_free) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_frame <= i_in.frame_now;
            r_fwd_addr <= w_addr;
            r_fwd_data <= r_s1_frame;
        end
        if (s1_move) begin
            r_s2_verdict <= verdict;
            if (verdict == VERDICT_LOCKED) begin
                r_s2_sat  <= diff >= WAIT_SAT_FRAMES;
                r_s2_diff <= diff[DIFF_W-1:0];
            end else begin
                r_s2_sat  <= 1'b0;
                r_s2_diff <= '0;
            end
        end
        if (r_s2_v && out_free) begin
            r_out_verdict <= r_s2_verdict;
            r_out_wait    <= wait_s2;
        end
    end

    // head moves only on a stored frame
    a_head_only_on_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && (verdict != VERDICT_ACCEPT)) |=> $stable(r_head))
        else $error("ring head moved on a refused attempt");

    // a new lock never ends before the attempt that set it
    a_lock_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && (verdict == VERDICT_FLOOD)) |=> (r_lock_until >= $past(r_s1_frame)))
        else $error("lock end behind flooding frame");

    // only a locked refusal carries a wait
    a_wait_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_out_verdict != VERDICT_LOCKED)) |-> (r_out_wait == '0))
        else $error("wait reported without a running lock");

    // a slot just stored is marked valid
    a_store_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_write |=> r_valid[$past(w_addr)])
        else $error("stored slot not marked valid");

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for message_flood_limiter, driving attempt beats and
// register writes, checking each verdict beat with a cycle-free model or a typed row.
// Depends on mfl_pkg, mfl_ifs and the message_flood_limiter top level.
module tb_top;
    import mfl_pkg::*;

    localparam int RING_DEPTH     = 16;
    localparam int CLK_PERIOD     = 4;
    localparam int FRAMES_PER_SEC = 10;
    localparam int IDLE_PCT       = 13;
    localparam int SETTLE_CYCLES  = 8;    // margin past the pipeline latency
    localparam int DRAIN_LIMIT    = 2000;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 100;
    localparam int LOG_CAP        = 50;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;   // not a register

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [WAIT_W-1:0]    wait_sec;
    } verdict_t;

    typedef struct {
        logic [FRAME_W-1:0] frame;
        verdict_t           v;
    } expected_t;

    typedef enum logic {ROW_CFG, ROW_ATTEMPT} row_kind_e;

    typedef struct {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DAT_W-1:0]  data;
        logic [FRAME_W-1:0]    frame;
        bit                    typed;
        verdict_t              exp;
    } stim_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    mfl_in_if  att_if ();
    mfl_out_if vrd_if ();

    message_flood_limiter #(.RING_DEPTH(RING_DEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (att_if),
        .o_out       (vrd_if)
    );

    // limiter model state
    logic [MAXMSG_W-1:0]  lim_msgs;
    logic [CFG_DAT_W-1:0] win_secs;
    logic [CFG_DAT_W-1:0] lock_len;
    logic [FRAME_W-1:0]   shadow_stamps [RING_DEPTH];
    int                   shadow_head;
    logic [FRAME_W-1:0]   shadow_lock_end;

    expected_t pending_verdicts [$];
    stim_row_t table_rows [$];
    int        error_count;
    bit        no_idle;

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        error_count++;
        // keep the log short on a badly broken build
        if (error_count <= LOG_CAP)
            $display("%0t: mismatch: %s", $time, msg);
    endtask

    function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DAT_W-1:0] data);
        case (idx)
            CFG_MAX_MESSAGES:   lim_msgs = data[MAXMSG_W-1:0];
            CFG_WINDOW_SECONDS: win_secs = data;
            CFG_LOCK_FRAMES:    lock_len = data;
            default: ;
        endcase
    endfunction

    function automatic verdict_t judge_attempt(input logic [FRAME_W-1:0] frame);
        verdict_t           v;
        int                 lim;
        int                 slot;
        logic [FRAME_W-1:0] stamp;
        logic [FRAME_W-1:0] age;
        logic [FRAME_W-1:0] remain;
        logic [FRAME_W:0]   lock_end;
        v.verdict  = VERDICT_ACCEPT;
        v.wait_sec = '0;
        if (lim_msgs == '0)
            return v;
        if (frame < shadow_lock_end) begin
            remain = (shadow_lock_end - frame) / FRAMES_PER_SEC;
            v.verdict  = VERDICT_LOCKED;
            v.wait_sec = (remain > FRAME_W'(WAIT_MAX)) ? WAIT_MAX : remain[WAIT_W-1:0];
            return v;
        end
        lim  = (int'(lim_msgs) > RING_DEPTH) ? RING_DEPTH : int'(lim_msgs);
        slot = (shadow_head + RING_DEPTH - (lim - 1)) % RING_DEPTH;
        stamp = shadow_stamps[slot];
        age   = frame - stamp;   // wraps modulo 2^32
        if (stamp != '0 && (age / FRAMES_PER_SEC) < FRAME_W'(win_secs)) begin
            lock_end = {1'b0, frame} + {17'd0, lock_len};
            shadow_lock_end = lock_end[FRAME_W] ? '1 : lock_end[FRAME_W-1:0];
            v.verdict = VERDICT_FLOOD;
            return v;
        end
        shadow_head = (shadow_head + 1) % RING_DEPTH;
        shadow_stamps[shadow_head] = frame;
        return v;
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DAT_W-1:0] data);
        stim_row_t row;
        row.kind  = ROW_CFG;
        row.idx   = idx;
        row.data  = data;
        row.frame = '0;
        row.typed = 1'b0;
        row.exp   = '0;
        table_rows.push_back(row);
    endfunction

    function automatic void add_try(input logic [FRAME_W-1:0] frame, input bit typed,
                                    input logic [VERDICT_W-1:0] verdict,
                                    input logic [WAIT_W-1:0] wait_sec);
        stim_row_t row;
        row.kind         = ROW_ATTEMPT;
        row.idx          = '0;
        row.data         = '0;
        row.frame        = frame;
        row.typed        = typed;
        row.exp.verdict  = verdict;
        row.exp.wait_sec = wait_sec;
        table_rows.push_back(row);
    endfunction

    // wait for every verdict, then let the pipeline empty
    task automatic settle();
        att_if.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller lowers it after the last write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        apply_cfg(idx, data);
    endtask

    task automatic send_attempt(input logic [FRAME_W-1:0] frame, input bit typed,
                                input verdict_t typed_exp);
        expected_t e;
        while (!no_idle && $urandom_range(99, 0) < IDLE_PCT) begin
            att_if.valid     <= 1'b0;
            att_if.frame_now <= $urandom;
            @(posedge i_clk);
        end
        att_if.valid     <= 1'b1;
        att_if.frame_now <= frame;
        do @(posedge i_clk); while (!att_if.ready);
        e.frame = frame;
        e.v     = judge_attempt(frame);
        if (typed)
            e.v = typed_exp;
        pending_verdicts.push_back(e);
    endtask

    task automatic run_rows(input int first, input int last);
        for (int r = first; r <= last; r++) begin
            if (table_rows[r].kind == ROW_CFG) begin
                if (r == first || table_rows[r-1].kind != ROW_CFG)
                    settle();
                cfg_write(table_rows[r].idx, table_rows[r].data);
                if (r == last || table_rows[r+1].kind != ROW_CFG)
                    cfg_we <= 1'b0;
            end else begin
                send_attempt(table_rows[r].frame, table_rows[r].typed, table_rows[r].exp);
            end
        end
    endtask

    // verdict side: random back-pressure
    initial begin
        vrd_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            vrd_if.ready <= no_idle || ($urandom_range(99, 0) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && vrd_if.valid && vrd_if.ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("verdict beat %0d with nothing expected",
                                          vrd_if.verdict));
            end else begin
                if (vrd_if.verdict !== pending_verdicts[0].v.verdict)
                    report_mismatch($sformatf("frame %h verdict %0d, expected %0d",
                                              pending_verdicts[0].frame, vrd_if.verdict,
                                              pending_verdicts[0].v.verdict));
                if (vrd_if.wait_seconds !== pending_verdicts[0].v.wait_sec)
                    report_mismatch($sformatf("frame %h wait %0d, expected %0d",
                                              pending_verdicts[0].frame, vrd_if.wait_seconds,
                                              pending_verdicts[0].v.wait_sec));
                void'(pending_verdicts.pop_front());
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int                   tail_start;
        int                   drain_cycles;
        int                   pick;
        logic [FRAME_W-1:0]   base;
        logic [FRAME_W-1:0]   frame;
        logic [MAXMSG_W-1:0]  max_val;
        logic [CFG_DAT_W-1:0] win_val;
        logic [CFG_DAT_W-1:0] lock_val;

        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        att_if.valid     <= 1'b0;
        att_if.frame_now <= '0;
        no_idle     = 1'b0;
        error_count = 0;
        lim_msgs    = RST_MAX_MESSAGES;
        win_secs    = CFG_DAT_W'(RST_WIN_FRAMES / FRAMES_PER_SEC);
        lock_len    = RST_LOCK_FRAMES;
        foreach (shadow_stamps[i])
            shadow_stamps[i] = '0;
        shadow_head     = 0;
        shadow_lock_end = '0;

        // upper data bits must be dropped by the 5-bit limit register
        add_cfg(CFG_MAX_MESSAGES, 16'hFFE2);
        add_try(32'd0, 1'b1, VERDICT_ACCEPT, 13'd0);          // stamp zero looks empty
        add_try(32'hFFFF_FFF0, 1'b1, VERDICT_ACCEPT, 13'd0);
        add_try(32'd5, 1'b0, VERDICT_ACCEPT, 13'd0);
        add_try(32'd6, 1'b0, VERDICT_ACCEPT, 13'd0);          // age wraps: flood
        add_try(32'd50, 1'b0, VERDICT_ACCEPT, 13'd0);
        add_try(32'd105, 1'b0, VERDICT_ACCEPT, 13'd0);
        add_try(32'd106, 1'b0, VERDICT_ACCEPT, 13'd0);
        add_cfg(CFG_MAX_MESSAGES, 16'd0);
        add_try(32'd107, 1'b1, VERDICT_ACCEPT, 13'd0);
        add_try(32'd0, 1'b1, VERDICT_ACCEPT, 13'd0);
        add_cfg(CFG_MAX_MESSAGES, 16'd31);                    // clamps to ring depth
        add_cfg(CFG_WINDOW_SECONDS, 16'hFFFF);
        add_cfg(CFG_LOCK_FRAMES, 16'd0);
        add_try(32'd200, 1'b0, VERDICT_ACCEPT, 13'd0);
        add_try(32'd201, 1'b0, VERDICT_ACCEPT, 13'd0);
        add_try(32'd202, 1'b0, VERDICT_ACCEPT, 13'd0);
        add_cfg(CFG_MAX_MESSAGES, 16'd1);
        add_cfg(CFG_LOCK_FRAMES, 16'hFFFF);
        add_try(32'd300000, 1'b0, VERDICT_ACCEPT, 13'd0);
        add_try(32'd1000, 1'b1, VERDICT_LOCKED, WAIT_MAX);    // wait saturates
        add_cfg(CFG_WINDOW_SECONDS, 16'd0);
        add_try(32'd365535, 1'b0, VERDICT_ACCEPT, 13'd0);
        add_cfg(CFG_SPARE_IDX, 16'hFFFF);
        add_try(32'd365540, 1'b0, VERDICT_ACCEPT, 13'd0);
        // a saturated lock end never clears, so these rows run last
        tail_start = table_rows.size();
        add_cfg(CFG_MAX_MESSAGES, 16'd1);
        add_cfg(CFG_WINDOW_SECONDS, 16'hFFFF);
        add_cfg(CFG_LOCK_FRAMES, 16'hFFFF);
        add_try(32'hFFFF_FF00, 1'b0, VERDICT_ACCEPT, 13'd0);
        add_try(32'hFFFF_FF10, 1'b0, VERDICT_ACCEPT, 13'd0);
        add_try(32'hFFFF_FFFE, 1'b0, VERDICT_ACCEPT, 13'd0);
        add_try(32'hFFFF_FFFF, 1'b0, VERDICT_ACCEPT, 13'd0);
        add_cfg(CFG_WINDOW_SECONDS, 16'd0);
        add_try(32'hFFFF_FFFF, 1'b0, VERDICT_ACCEPT, 13'd0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_rows(0, tail_start - 1);

        base = 32'd400000;
        for (int p = 0; p < PHASES; p++) begin
            settle();
            no_idle = (p == 5 || p == 6);
            pick = $urandom_range(9, 0);
            if (pick == 0)
                max_val = '0;
            else if (pick == 1)
                max_val = 5'd16;
            else if (pick == 2)
                max_val = 5'($urandom_range(31, 17));
            else
                max_val = 5'($urandom_range(6, 1));
            pick = $urandom_range(7, 0);
            win_val = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'($urandom)
                                             : 16'($urandom_range(6, 0));
            pick = $urandom_range(7, 0);
            lock_val = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'($urandom)
                     : (pick == 2) ? 16'd0 : 16'($urandom_range(150, 1));
            if ($urandom_range(3, 0) == 0)
                cfg_write(CFG_SPARE_IDX, 16'($urandom));
            cfg_write(CFG_MAX_MESSAGES, (16'($urandom) & 16'hFFE0) | {11'd0, max_val});
            cfg_write(CFG_WINDOW_SECONDS, win_val);
            cfg_write(CFG_LOCK_FRAMES, lock_val);
            cfg_we <= 1'b0;
            // skip past a long lock so the phase exercises the ring
            if (base < shadow_lock_end)
                base = shadow_lock_end + 32'($urandom_range(20, 0));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99, 0);
                if (pick < 80) begin
                    base  = base + 32'($urandom_range(6, 0));
                    frame = base;
                end else if (pick < 88) begin
                    base  = base + 32'($urandom_range(400, 7));
                    frame = base;
                end else if (pick < 95) begin
                    frame = base - 32'($urandom_range(200000, 0));
                end else begin
                    frame = $urandom;
                end
                send_attempt(frame, 1'b0, '0);
            end
        end
        no_idle = 1'b0;

        run_rows(tail_start, table_rows.size() - 1);

        att_if.valid <= 1'b0;
        drain_cycles = 0;
        while (pending_verdicts.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_verdicts.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
